FILE: rtl/core/drs_pkg.sv
// Package for the decimal radix sort core: digit type and the constants of
// the divide-by-ten unit. It depends on nothing else.
`default_nettype none
package drs_pkg;
    localparam int RADIX      = 10;
    localparam int DIGITS_MAX = 10;

    // Divide by ten as a multiplication by a reciprocal: q / 10 equals
    // (q * RECIP10) >> RECIP10_SHIFT for every 32-bit q.
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    typedef logic [3:0] t_digit;
endpackage
`default_nettype wire

FILE: rtl/core/drs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stands alone; used for both value banks of the sort core.
`default_nettype none
module drs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/drs_div10.sv
// Divide-by-ten unit: one registered reciprocal multiply, then the quotient
// and the low decimal digit. Depends on drs_pkg.
`default_nettype none
module drs_div10 #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic [VALUE_BITS-1:0]   i_q,
    output drs_pkg::t_digit              o_digit,
    output logic      [VALUE_BITS-1:0]   o_quot
);
    import drs_pkg::*;

    logic [63:0]           r_prod;
    logic [VALUE_BITS-1:0] r_q;
    logic [VALUE_BITS-1:0] times10;
    logic [VALUE_BITS-1:0] rem;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(32'(i_q)) * 64'(RECIP10);
        r_q    <= i_q;
    end

    assign o_quot  = VALUE_BITS'(r_prod >> RECIP10_SHIFT);
    assign times10 = (o_quot << 3) + (o_quot << 1);
    assign rem     = r_q - times10;
    assign o_digit = rem[3:0];
endmodule
`default_nettype wire

FILE: rtl/core/decimal_radix_sort_core.sv
// Decimal radix sort core: loads a set of values, sorts them by an LSD base-10
// radix sort and streams them out in ascending order. Depends on drs_pkg.
//
// Values load one item per cycle while the core is idle; the item marked last
// starts the sort. Items beyond MAX_ITEMS are dropped and flagged on every
// result of the set. Each entry is kept with its running quotient by ten in one
// of two RAM banks; a pass reads the source bank entry by entry through the
// divide-by-ten multiplier, first to count the ten buckets and then to scatter
// into the other bank. The core sorts on min(digit_passes, 10) digits, then
// returns the results one at a time, each held until the output side takes
// it. No new item is taken from the last item of a set until its last result
// leaves.
`default_nettype none
module decimal_radix_sort_core #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_value,
    input  wire logic        i_last_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [31:0] o_sorted_value,
    output logic             o_end_of_set,
    output logic             o_overflowed,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data
);
    import drs_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int MW = 2 * VALUE_BITS;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CNT_RD  = 4'd1;
    localparam logic [3:0] S_CNT_MUL = 4'd2;
    localparam logic [3:0] S_CNT_USE = 4'd3;
    localparam logic [3:0] S_PREFIX  = 4'd4;
    localparam logic [3:0] S_SCT_RD  = 4'd5;
    localparam logic [3:0] S_SCT_MUL = 4'd6;
    localparam logic [3:0] S_SCT_USE = 4'd7;
    localparam logic [3:0] S_OUT_RD  = 4'd8;
    localparam logic [3:0] S_OUT_LD  = 4'd9;
    localparam logic [3:0] S_OUT_HLD = 4'd10;

    logic [3:0]            r_state;
    logic [CW-1:0]         r_cnt;
    logic                  r_ovf;
    logic [3:0]            r_passes;
    logic [3:0]            r_pass;
    logic                  r_src;
    logic [AW-1:0]         r_idx;
    t_digit                r_didx;
    logic [CW-1:0]         r_acc;
    logic [CW-1:0]         r_bucket [RADIX];
    logic                  r_o_valid;
    logic [VALUE_BITS-1:0] r_o_val;
    logic                  r_o_eos;
    logic                  r_o_ovf;

    logic [3:0]            passes_eff;
    logic                  in_acc;
    logic                  out_acc;
    logic                  last_idx;
    logic                  we;
    logic                  wbank;
    logic [AW-1:0]         waddr;
    logic [MW-1:0]         wdata;
    logic [MW-1:0]         rd0;
    logic [MW-1:0]         rd1;
    logic [MW-1:0]         rd;
    logic [VALUE_BITS-1:0] rd_value;
    logic [VALUE_BITS-1:0] rd_quot;
    t_digit                dig;
    logic [VALUE_BITS-1:0] quot;
    logic [VALUE_BITS-1:0] in_v;

    assign passes_eff = (r_passes > 4'(DIGITS_MAX)) ? 4'(DIGITS_MAX) : r_passes;
    assign o_ready    = (r_state == S_IDLE);
    assign in_acc     = i_valid & o_ready;
    assign out_acc    = r_o_valid & i_ready;
    assign last_idx   = (CW'(r_idx) == r_cnt - CW'(1));
    assign in_v       = i_value[VALUE_BITS-1:0];

    assign rd       = r_src ? rd1 : rd0;
    assign rd_value = rd[MW-1:VALUE_BITS];
    assign rd_quot  = rd[VALUE_BITS-1:0];

    // Loads go into the source bank; the scatter writes the other one.
    always_comb begin
        we    = 1'b0;
        wbank = r_src;
        waddr = r_cnt[AW-1:0];
        wdata = {in_v, in_v};
        if (r_state == S_IDLE) begin
            we = in_acc && (r_cnt < CW'(MAX_ITEMS));
        end else if (r_state == S_SCT_USE) begin
            we    = 1'b1;
            wbank = ~r_src;
            waddr = r_bucket[dig][AW-1:0];
            wdata = {rd_value, quot};
        end
    end

    drs_ram #(.WIDTH(MW), .DEPTH(MAX_ITEMS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we & ~wbank),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rd0)
    );

    drs_ram #(.WIDTH(MW), .DEPTH(MAX_ITEMS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we & wbank),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rd1)
    );

    drs_div10 #(.VALUE_BITS(VALUE_BITS)) u_div10 (
        .i_clk   (i_clk),
        .i_q     (rd_quot),
        .o_digit (dig),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_passes  <= 4'(DIGITS_MAX);
            r_pass    <= '0;
            r_src     <= 1'b0;
            r_idx     <= '0;
            r_didx    <= '0;
            r_acc     <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < RADIX; i++) begin
                r_bucket[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_passes <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_cnt < CW'(MAX_ITEMS)) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_item) begin
                            r_idx  <= '0;
                            r_pass <= '0;
                            for (int i = 0; i < RADIX; i++) begin
                                r_bucket[i] <= '0;
                            end
                            r_state <= (passes_eff == 4'd0) ? S_OUT_RD : S_CNT_RD;
                        end
                    end
                end
                S_CNT_RD:  r_state <= S_CNT_MUL;
                S_CNT_MUL: r_state <= S_CNT_USE;
                S_CNT_USE: begin
                    r_bucket[dig] <= r_bucket[dig] + CW'(1);
                    if (last_idx) begin
                        r_didx  <= '0;
                        r_acc   <= '0;
                        r_state <= S_PREFIX;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_CNT_RD;
                    end
                end
                S_PREFIX: begin
                    // Bucket counts become the start address of each bucket.
                    r_bucket[r_didx] <= r_acc;
                    r_acc            <= r_acc + r_bucket[r_didx];
                    if (r_didx == t_digit'(RADIX - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_SCT_RD;
                    end else begin
                        r_didx <= r_didx + t_digit'(1);
                    end
                end
                S_SCT_RD:  r_state <= S_SCT_MUL;
                S_SCT_MUL: r_state <= S_SCT_USE;
                S_SCT_USE: begin
                    if (last_idx) begin
                        r_src  <= ~r_src;
                        r_pass <= r_pass + 4'd1;
                        r_idx  <= '0;
                        for (int i = 0; i < RADIX; i++) begin
                            r_bucket[i] <= '0;
                        end
                        r_state <= (r_pass + 4'd1 == passes_eff) ? S_OUT_RD : S_CNT_RD;
                    end else begin
                        r_bucket[dig] <= r_bucket[dig] + CW'(1);
                        r_idx         <= r_idx + AW'(1);
                        r_state       <= S_SCT_RD;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_LD;
                S_OUT_LD: begin
                    r_o_valid <= 1'b1;
                    r_o_val   <= rd_value;
                    r_o_eos   <= last_idx;
                    r_o_ovf   <= r_ovf;
                    r_state   <= S_OUT_HLD;
                end
                S_OUT_HLD: begin
                    if (out_acc) begin
                        r_o_valid <= 1'b0;
                        if (r_o_eos) begin
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_sorted_value = 32'(r_o_val);
    assign o_end_of_set   = r_o_eos;
    assign o_overflowed   = r_o_ovf;
endmodule
`default_nettype wire
